// ----- rtl/tspc_pkg.sv -----
`default_nettype none

package tspc_pkg;

	localparam int SCREEN_WIDTH  = 256;
	localparam int SCREEN_HEIGHT = 240;

	localparam int FS_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int FS_AW    = $clog2(FS_DEPTH);

	// Signed horizontal position: room for column - 8 and for the screen width.
	localparam int XW = 12;

	localparam int PAL_DEPTH = 32;
	localparam int PAL_AW    = $clog2(PAL_DEPTH);

	typedef enum logic [1:0] {
		OP_PAL  = 2'd0,
		OP_BG   = 2'd1,
		OP_SPR  = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef struct packed {
		logic              onscreen;
		logic              last;
		logic              is_read;
		logic              is_spr;
		logic              zero;
		logic              behind;
		logic [1:0]        value;
		logic [PAL_AW-1:0] pidx;
		logic [7:0]        line;
		logic [7:0]        col;
		logic [FS_AW-1:0]  addr;
	} pix_t;

	typedef struct packed {
		logic             en;
		logic [FS_AW-1:0] addr;
		logic [5:0]       data;
	} fs_wr_t;

endpackage

`default_nettype wire

// ----- rtl/tspc_frame_store.sv -----
`default_nettype none

module tspc_frame_store (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire tspc_pkg::fs_wr_t   wr,
	input  wire                     rd_en,
	input  wire [tspc_pkg::FS_AW-1:0] rd_addr,
	output logic [5:0]              rd_data,
	output logic                    busy
);
	import tspc_pkg::*;

	logic [5:0]       mem [FS_DEPTH];
	logic [5:0]       rd_q;
	logic [FS_AW-1:0] clr_cnt_q;
	logic             clr_busy_q;

	logic             we;
	logic [FS_AW-1:0] wa;
	logic [5:0]       wd;

	always_comb begin
		if (clr_busy_q) begin
			we = 1'b1;
			wa = clr_cnt_q;
			wd = '0;
		end else begin
			we = wr.en;
			wa = wr.addr;
			wd = wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// After reset every entry is swept to zero, one per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == FS_AW'(FS_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign rd_data = rd_q;
	assign busy    = clr_busy_q;

endmodule

`default_nettype wire

// ----- rtl/tspc_pixel_gen.sv -----
`default_nettype none

module tspc_pixel_gen (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       load,
	input  wire tspc_pkg::op_t        op,
	input  wire [7:0]                 line,
	input  wire [8:0]                 column,
	input  wire [7:0]                 plane_high,
	input  wire [7:0]                 plane_low,
	input  wire [7:0]                 attribute,
	input  wire                       sprite_zero,
	input  wire                       s1_fire,
	output logic                      busy,
	output logic                      valid_s1,
	output tspc_pkg::pix_t            pix_s1,
	output logic                      rd_en,
	output logic [tspc_pkg::FS_AW-1:0] rd_addr
);
	import tspc_pkg::*;

	logic                 gen_q;
	logic                 read_q;
	logic                 spr_q;
	logic                 zero_q;
	logic                 behind_q;
	logic [1:0]           pal_q;
	logic [7:0]           line_q;
	logic signed [XW-1:0] x_q;
	logic [7:0]           hi_q;
	logic [7:0]           lo_q;
	logic [2:0]           cnt_q;
	logic [FS_AW-1:0]     row_base_q;

	logic       is_spr;
	logic       flip;
	logic [8:0] colm8;
	logic [1:0] quad;
	logic [1:0] pal_d;
	logic [7:0] hi_d;
	logic [7:0] lo_d;
	pix_t       cur;
	logic       adv;

	always_comb begin
		is_spr = (op == OP_SPR);
		flip   = is_spr && attribute[6];
		colm8  = column - 9'd8;
		quad   = {line[4], colm8[4]};
		case (quad)
			2'd0:    pal_d = attribute[1:0];
			2'd1:    pal_d = attribute[3:2];
			2'd2:    pal_d = attribute[5:4];
			default: pal_d = attribute[7:6];
		endcase
		if (is_spr) begin
			pal_d = attribute[1:0];
		end
		for (int b = 0; b < 8; b++) begin
			hi_d[b] = flip ? plane_high[7-b] : plane_high[b];
			lo_d[b] = flip ? plane_low[7-b]  : plane_low[b];
		end
	end

	always_comb begin
		cur.onscreen = (line_q < 8'(SCREEN_HEIGHT) || SCREEN_HEIGHT > 255)
			&& (x_q >= 0) && (x_q < $signed(XW'(SCREEN_WIDTH)));
		cur.last     = read_q || (cnt_q == 3'd7)
			|| (x_q == $signed(XW'(SCREEN_WIDTH - 1)));
		cur.is_read  = read_q;
		cur.is_spr   = spr_q;
		cur.zero     = zero_q;
		cur.behind   = behind_q;
		cur.value    = {hi_q[7], lo_q[7]};
		cur.pidx     = {spr_q, pal_q, hi_q[7], lo_q[7]};
		cur.line     = line_q;
		cur.col      = x_q[7:0];
		cur.addr     = row_base_q + FS_AW'($unsigned(x_q));
	end

	assign adv     = gen_q && (!valid_s1 || s1_fire);
	assign rd_en   = adv && cur.onscreen;
	assign rd_addr = cur.addr;
	assign busy    = gen_q || valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (load) begin
				gen_q <= 1'b1;
			end else if (adv && cur.last) begin
				gen_q <= 1'b0;
			end
			if (adv) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			read_q     <= (op == OP_READ);
			spr_q      <= is_spr;
			zero_q     <= sprite_zero;
			behind_q   <= attribute[5];
			pal_q      <= pal_d;
			line_q     <= line;
			x_q        <= (op == OP_READ) ? $signed(XW'(column))
				: $signed(XW'(column)) - $signed(XW'(8));
			hi_q       <= hi_d;
			lo_q       <= lo_d;
			cnt_q      <= '0;
			row_base_q <= FS_AW'(line * SCREEN_WIDTH);
		end else if (adv) begin
			hi_q  <= {hi_q[6:0], 1'b0};
			lo_q  <= {lo_q[6:0], 1'b0};
			cnt_q <= cnt_q + 3'd1;
			x_q   <= x_q + $signed(XW'(1));
		end
		if (adv) begin
			pix_s1 <= cur;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tspc_pixel_eval.sv -----
`default_nettype none

module tspc_pixel_eval (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        pal_we,
	input  wire [tspc_pkg::PAL_AW-1:0] pal_slot,
	input  wire [5:0]                  pal_value,
	input  wire                        valid_s1,
	input  wire tspc_pkg::pix_t        pix_s1,
	input  wire [5:0]                  rd_data,
	output logic                       s1_fire,
	output tspc_pkg::fs_wr_t           fs_wr,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [7:0]                 pixel_line,
	output logic [7:0]                 pixel_column,
	output logic [5:0]                 color_index,
	output logic                       drawn,
	output logic                       hit_flag,
	output logic [7:0]                 hit_line,
	output logic                       last
);
	import tspc_pkg::*;

	logic [5:0] pal_q [PAL_DEPTH];
	logic [7:0] hit_line_q;
	logic       out_valid_q;
	logic [7:0] line_q;
	logic [7:0] col_q;
	logic [5:0] color_q;
	logic       drawn_q;
	logic       hit_q;
	logic [7:0] hit_out_q;
	logic       last_q;

	logic       needs_out;
	logic       out_free;
	logic [5:0] color;
	logic       over_bg;
	logic       wr;
	logic       hit;
	logic [5:0] res_color;

	always_comb begin
		color     = pal_q[pix_s1.pidx];
		over_bg   = (rd_data != pal_q[0]);
		needs_out = pix_s1.onscreen || pix_s1.is_read;
		out_free  = !out_valid_q || out_ready;
		s1_fire   = valid_s1 && (!needs_out || out_free);
		wr        = 1'b0;
		hit       = 1'b0;
		if (pix_s1.onscreen && !pix_s1.is_read) begin
			if (!pix_s1.is_spr) begin
				wr = 1'b1;
			end else if (pix_s1.value != 2'd0) begin
				hit = pix_s1.zero && over_bg;
				wr  = !(over_bg && pix_s1.behind);
			end
		end
		if (wr) begin
			res_color = color;
		end else if (pix_s1.onscreen) begin
			res_color = rd_data;
		end else begin
			res_color = '0;
		end
		fs_wr.en   = s1_fire && wr;
		fs_wr.addr = pix_s1.addr;
		fs_wr.data = color;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAL_DEPTH; i++) begin
				pal_q[i] <= '0;
			end
			hit_line_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pal_we) begin
				pal_q[pal_slot] <= pal_value;
			end
			if (s1_fire && hit) begin
				hit_line_q <= pix_s1.line;
			end
			if (s1_fire && needs_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && needs_out) begin
			line_q    <= pix_s1.line;
			col_q     <= pix_s1.col;
			color_q   <= res_color;
			drawn_q   <= wr;
			hit_q     <= hit;
			hit_out_q <= hit ? pix_s1.line : hit_line_q;
			last_q    <= pix_s1.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_line   = line_q;
	assign pixel_column = col_q;
	assign color_index  = color_q;
	assign drawn        = drawn_q;
	assign hit_flag     = hit_q;
	assign hit_line     = hit_out_q;
	assign last         = last_q;

endmodule

`default_nettype wire

// ----- rtl/tile_sprite_pixel_compositor_top.sv -----
// Tile and sprite pixel compositor.
// Input channel (in_valid/in_ready) takes one operation per transfer: a palette
// write, a background tile row, a sprite tile row or a single pixel read.
// Output channel (out_valid/out_ready) gives one transfer per reported pixel,
// with last marking the final pixel of the operation.
// A palette write gives no output. A row of up to eight pixels is walked one
// pixel per cycle while the receiver keeps up, through bit-plane shift registers,
// with a read-modify-write of the frame store for each pixel; a pixel read
// walks a single pixel. An operation is registered in the pixel generator,
// then in pix_s1 with the frame store read, then in the output register.
// The frame store has one write and one registered read port; the read for
// the next pixel overlaps the write of the current one.
// After reset the frame store is swept to zero, one entry per cycle, over all
// 61440 entries; in_ready stays low meanwhile. Palette and hit line reset to zero.
// When the receiver stalls, the output register holds its transfer and the
// pixel walk pauses; a new operation is taken while the last output waits.
`default_nettype none

module tile_sprite_pixel_compositor_top (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire [1:0]  op,
	input  wire [7:0]  line,
	input  wire [8:0]  column,
	input  wire [7:0]  plane_high,
	input  wire [7:0]  plane_low,
	input  wire [7:0]  attribute,
	input  wire        sprite_zero,
	input  wire [4:0]  palette_slot,
	input  wire [5:0]  palette_value,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] pixel_line,
	output logic [7:0] pixel_column,
	output logic [5:0] color_index,
	output logic       drawn,
	output logic       hit_flag,
	output logic [7:0] hit_line,
	output logic       last
);
	import tspc_pkg::*;

	op_t              op_in;
	logic             in_fire;
	logic             gen_busy;
	logic             fs_busy;
	logic             valid_s1;
	pix_t             pix_s1;
	logic             s1_fire;
	logic             rd_en;
	logic [FS_AW-1:0] rd_addr;
	logic [5:0]       rd_data;
	fs_wr_t           fs_wr;

	assign op_in    = op_t'(op);
	assign in_ready = !fs_busy && !gen_busy;
	assign in_fire  = in_valid && in_ready;

	tspc_pixel_gen u_gen (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (in_fire && op_in != OP_PAL),
		.op          (op_in),
		.line        (line),
		.column      (column),
		.plane_high  (plane_high),
		.plane_low   (plane_low),
		.attribute   (attribute),
		.sprite_zero (sprite_zero),
		.s1_fire     (s1_fire),
		.busy        (gen_busy),
		.valid_s1    (valid_s1),
		.pix_s1      (pix_s1),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr)
	);

	tspc_frame_store u_fs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fs_wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.busy    (fs_busy)
	);

	tspc_pixel_eval u_eval (
		.clk          (clk),
		.arst_n       (arst_n),
		.pal_we       (in_fire && op_in == OP_PAL),
		.pal_slot     (palette_slot),
		.pal_value    (palette_value),
		.valid_s1     (valid_s1),
		.pix_s1       (pix_s1),
		.rd_data      (rd_data),
		.s1_fire      (s1_fire),
		.fs_wr        (fs_wr),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_line   (pixel_line),
		.pixel_column (pixel_column),
		.color_index  (color_index),
		.drawn        (drawn),
		.hit_flag     (hit_flag),
		.hit_line     (hit_line),
		.last         (last)
	);

endmodule

`default_nettype wire

// ----- rtl/tspc_checker.sv -----
`default_nettype none

module tspc_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_ready,
	input wire [1:0] op,
	input wire       out_valid,
	input wire       out_ready,
	input wire [7:0] pixel_line,
	input wire [7:0] pixel_column,
	input wire [5:0] color_index,
	input wire       hit_flag,
	input wire [7:0] hit_line,
	input wire       last
);
	import tspc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transfer withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pixel_column) && $stable(color_index)
			&& $stable(last))
		else $error("output payload changed while stalled");

	a_hit_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_flag |-> hit_line == pixel_line)
		else $error("hit line does not follow the hit pixel");

	a_busy_after_op: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op != OP_PAL |=> !in_ready)
		else $error("new operation taken while a row is in progress");

endmodule

bind tile_sprite_pixel_compositor_top tspc_checker u_tspc_checker (.*);

`default_nettype wire
